@@ rtl/fuzzy_duty_regulator_defines.svh @@
// assertion helpers shared by the regulator modules
`ifndef FUZZY_DUTY_REGULATOR_DEFINES_SVH
`define FUZZY_DUTY_REGULATOR_DEFINES_SVH

// condition must hold at every clock edge out of reset
`define FDR_ASSERT_NOW(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define FDR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/fdr_pkg.sv @@
package fdr_pkg;

    // samples averaged per tick, clamped to the five sample fields
    localparam int SAMPLES_PER_TICK  = 5;
    localparam int NUM_SAMPLE_FIELDS = 5;
    localparam int N_AVG = (SAMPLES_PER_TICK < 1) ? 1 :
                           ((SAMPLES_PER_TICK > NUM_SAMPLE_FIELDS) ? NUM_SAMPLE_FIELDS :
                            SAMPLES_PER_TICK);

    localparam int SMP_W  = 12;
    localparam int MV_W   = 12;
    localparam int REF_W  = 12;
    localparam int PER_W  = 16;
    localparam int DUTY_W = 16;
    localparam int LVL_W  = 4;
    localparam int ERR_W  = 14;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_REF_MV     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PWM_PERIOD = 1'd1;

    localparam logic [REF_W-1:0] REF_MV_RESET     = 12'd0;
    localparam logic [PER_W-1:0] PWM_PERIOD_RESET = 16'd1000;

    localparam int Q_DEPTH = 4;

    // class codes
    localparam logic [LVL_W-1:0] LVL_NE = 4'd0;
    localparam logic [LVL_W-1:0] LVL_NH = 4'd1;
    localparam logic [LVL_W-1:0] LVL_NM = 4'd2;
    localparam logic [LVL_W-1:0] LVL_NS = 4'd3;
    localparam logic [LVL_W-1:0] LVL_NT = 4'd4;
    localparam logic [LVL_W-1:0] LVL_Z  = 4'd5;
    localparam logic [LVL_W-1:0] LVL_PT = 4'd6;
    localparam logic [LVL_W-1:0] LVL_PS = 4'd7;
    localparam logic [LVL_W-1:0] LVL_PM = 4'd8;
    localparam logic [LVL_W-1:0] LVL_PH = 4'd9;
    localparam logic [LVL_W-1:0] LVL_PE = 4'd10;

    typedef struct packed {
        logic [SMP_W-1:0] sample_0;
        logic [SMP_W-1:0] sample_1;
        logic [SMP_W-1:0] sample_2;
        logic [SMP_W-1:0] sample_3;
        logic [SMP_W-1:0] sample_4;
    } t_in_item;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic [MV_W-1:0]   measured_mv;
        logic [LVL_W-1:0]  error_level;
        logic [LVL_W-1:0]  change_level;
        logic [LVL_W-1:0]  rule_level;
    } t_out_item;

    // queue status: full holds back the front end, empty holds back the back end
    typedef struct packed {
        logic empty;
        logic full;
    } t_q_status;

endpackage

@@ rtl/fdr_front.sv @@
module fdr_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  fdr_pkg::t_in_item  i_in_data,
    output logic               o_push,
    input  logic               i_full,
    output logic [fdr_pkg::MV_W-1:0] o_mv
);
    import fdr_pkg::*;

    localparam int SUM_W       = SMP_W + $clog2(N_AVG);
    // floor(sum / N_AVG) by reciprocal, exact for the full sum range
    localparam int AVG_SHIFT   = 17;
    localparam int AVG_MAGIC_W = AVG_SHIFT + 1;
    localparam int AVG_MAGIC   = ((1 << AVG_SHIFT) + N_AVG - 1) / N_AVG;
    localparam int AVG_PROD_W  = SUM_W + AVG_MAGIC_W;
    // 3300/4095 reduces to 220/273
    localparam int MV_NUM      = 220;
    localparam int MV_DEN      = 273;
    localparam int MV_SHIFT    = 22;
    localparam int MV_MAGIC_W  = 22;
    localparam int MV_MAGIC    =
        int'((longint'(MV_NUM) * (longint'(1) << MV_SHIFT) + longint'(MV_DEN - 1)) /
             longint'(MV_DEN));
    localparam int MV_PROD_W   = SMP_W + MV_MAGIC_W;

    logic [SMP_W-1:0]      w_samp [NUM_SAMPLE_FIELDS];
    logic                  w_adv;
    logic                  r_v1, r_v2, r_v3;
    logic [SUM_W-1:0]      r_sum, n_sum;
    logic [SMP_W-1:0]      r_avg, n_avg;
    logic [MV_W-1:0]       r_mv, n_mv;
    logic [AVG_PROD_W-1:0] w_avg_prod;
    logic [MV_PROD_W-1:0]  w_mv_prod;

    assign w_samp[0] = i_in_data.sample_0;
    assign w_samp[1] = i_in_data.sample_1;
    assign w_samp[2] = i_in_data.sample_2;
    assign w_samp[3] = i_in_data.sample_3;
    assign w_samp[4] = i_in_data.sample_4;

    always_comb begin
        n_sum = '0;
        for (int i = 0; i < N_AVG; i++) begin
            n_sum = n_sum + SUM_W'(w_samp[i]);
        end
    end

    assign w_avg_prod = AVG_PROD_W'(r_sum) * AVG_PROD_W'(AVG_MAGIC);
    assign n_avg      = w_avg_prod[AVG_SHIFT +: SMP_W];
    assign w_mv_prod  = MV_PROD_W'(r_avg) * MV_PROD_W'(MV_MAGIC);
    assign n_mv       = w_mv_prod[MV_SHIFT +: MV_W];

    // the whole front moves together unless the last beat cannot enter the queue
    assign w_adv      = !r_v3 || !i_full;
    assign o_in_stall = !w_adv;
    assign o_push     = r_v3 && !i_full;
    assign o_mv       = r_mv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (w_adv) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_sum <= n_sum;
            r_avg <= n_avg;
            r_mv  <= n_mv;
        end
    end

endmodule

@@ rtl/fdr_queue.sv @@
`include "fuzzy_duty_regulator_defines.svh"

module fdr_queue (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    input  logic [fdr_pkg::MV_W-1:0]  i_data,
    input  logic                      i_pop,
    output fdr_pkg::t_q_status        o_status,
    output logic [fdr_pkg::MV_W-1:0]  o_data
);
    import fdr_pkg::*;

    localparam int Q_PTR_W = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    logic [MV_W-1:0]    r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CNT_W-1:0] r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    assign o_data         = r_mem[r_rd_ptr];
    assign o_status.empty = (r_count == '0);
    assign o_status.full  = (r_count == Q_CNT_W'(Q_DEPTH));

    `FDR_ASSERT_NOW(a_q_no_overflow, !(i_push && o_status.full), "push into a full queue")
    `FDR_ASSERT_NOW(a_q_no_underflow, !(i_pop && o_status.empty), "pop from an empty queue")

endmodule

@@ rtl/fdr_back.sv @@
`include "fuzzy_duty_regulator_defines.svh"

module fdr_back (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [fdr_pkg::REF_W-1:0]  i_ref_mv,
    input  logic [fdr_pkg::PER_W-1:0]  i_pwm_period,
    input  fdr_pkg::t_q_status         i_q_status,
    input  logic [fdr_pkg::MV_W-1:0]   i_mv,
    output logic                       o_pop,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output fdr_pkg::t_out_item         o_out_data
);
    import fdr_pkg::*;

    localparam int CLS_W     = 26;
    localparam int K_W       = 10;
    localparam int PK_W      = PER_W + K_W;
    localparam int MAG_W     = 23;
    localparam int STEP_SH   = 26;
    localparam int PM_W      = PER_W + MAG_W;
    localparam int STEP_W    = 12;
    localparam int GUARD_W   = 30;
    localparam int UP_W      = 20;

    localparam logic signed [CLS_W-1:0] K1000 = 26'sd1000;
    localparam logic signed [CLS_W-1:0] K5    = 26'sd5;
    localparam logic signed [CLS_W-1:0] K100  = 26'sd100;
    localparam logic signed [CLS_W-1:0] K200  = 26'sd200;
    localparam logic signed [CLS_W-1:0] K350  = 26'sd350;
    localparam logic signed [CLS_W-1:0] K450  = 26'sd450;

    // sorts x into a class by 1000*x against k*ref
    function automatic logic [LVL_W-1:0] classify(input logic signed [ERR_W-1:0] x,
                                                  input logic [REF_W-1:0] ref_val);
        logic signed [CLS_W-1:0] v, r, t5, t100, t200, t350, t450;
        logic [LVL_W-1:0] lvl;
        v    = CLS_W'(x) * K1000;
        r    = $signed({{(CLS_W - REF_W){1'b0}}, ref_val});
        t5   = r * K5;
        t100 = r * K100;
        t200 = r * K200;
        t350 = r * K350;
        t450 = r * K450;
        if (v > -t5 && v <= t5)            lvl = LVL_Z;
        else if (v > t5 && v <= t100)      lvl = LVL_PT;
        else if (v > -t100 && v <= -t5)    lvl = LVL_NT;
        else if (v > t100 && v <= t200)    lvl = LVL_PS;
        else if (v > -t200 && v <= -t100)  lvl = LVL_NS;
        else if (v > t200 && v <= t350)    lvl = LVL_PM;
        else if (v > -t350 && v <= -t200)  lvl = LVL_NM;
        else if (v > t350 && v <= t450)    lvl = LVL_PH;
        else if (v > -t450 && v <= -t350)  lvl = LVL_NH;
        else if (v > t450)                 lvl = LVL_PE;
        else                               lvl = LVL_NE;
        return lvl;
    endfunction

    function automatic logic [LVL_W-1:0] rule_of(input logic [LVL_W-1:0] el,
                                                 input logic [LVL_W-1:0] cl);
        logic signed [5:0] s;
        logic [4:0] m;
        logic [2:0] mag;
        s = $signed({2'b00, el}) + $signed({2'b00, cl}) - 6'sd10;
        m = (s < 0) ? 5'(-s) : 5'(s);
        case (m) inside
            5'd0:         mag = 3'd0;
            5'd1:         mag = 3'd1;
            5'd2:         mag = 3'd2;
            [5'd3:5'd4]:  mag = 3'd3;
            [5'd5:5'd6]:  mag = 3'd4;
            default:      mag = 3'd5;
        endcase
        return (s < 0) ? LVL_Z - LVL_W'(mag) : LVL_Z + LVL_W'(mag);
    endfunction

    // step fraction in units of 1/10000
    function automatic logic [K_W-1:0] step_k(input logic [LVL_W-1:0] rl);
        logic [K_W-1:0] k;
        case (rl)
            LVL_NE, LVL_PE: k = 10'd625;
            LVL_NH:         k = 10'd370;
            LVL_PH:         k = 10'd400;
            LVL_NM, LVL_PM: k = 10'd250;
            LVL_NS, LVL_PS: k = 10'd120;
            LVL_NT, LVL_PT: k = 10'd50;
            default:        k = '0;
        endcase
        return k;
    endfunction

    // ceil(2^26 * k / 10000), exact floor for any 16-bit period
    function automatic logic [MAG_W-1:0] step_magic(input logic [LVL_W-1:0] rl);
        logic [MAG_W-1:0] m;
        case (rl)
            LVL_NE, LVL_PE: m = 23'd4194304;
            LVL_NH:         m = 23'd2483028;
            LVL_PH:         m = 23'd2684355;
            LVL_NM, LVL_PM: m = 23'd1677722;
            LVL_NS, LVL_PS: m = 23'd805307;
            LVL_NT, LVL_PT: m = 23'd335545;
            default:        m = '0;
        endcase
        return m;
    endfunction

    logic w_adv;

    logic                    r_b1_valid;
    logic [MV_W-1:0]         r_b1_mv;
    logic signed [ERR_W-1:0] r_b1_err, n_b1_err;
    logic signed [ERR_W-1:0] r_b1_chg, n_b1_chg;
    logic signed [ERR_W-1:0] r_prev_err;

    logic                    r_b2_valid;
    logic [MV_W-1:0]         r_b2_mv;
    logic [LVL_W-1:0]        r_b2_el, r_b2_cl;

    logic                    r_b3_valid;
    logic [MV_W-1:0]         r_b3_mv;
    logic [LVL_W-1:0]        r_b3_el, r_b3_cl, r_b3_rule, n_b3_rule;
    logic [PK_W-1:0]         r_b3_pk, n_b3_pk;
    logic [STEP_W-1:0]       r_b3_step, n_b3_step;
    logic [PM_W-1:0]         w_pm;

    logic [DUTY_W-1:0]       r_duty, n_duty;
    logic                    r_out_valid;
    t_out_item               r_out;

    assign w_adv = !r_out_valid || !i_out_stall;
    assign o_pop = w_adv && !i_q_status.empty;

    assign n_b1_err = $signed({2'b00, i_ref_mv}) - $signed({2'b00, i_mv});
    assign n_b1_chg = n_b1_err - r_prev_err;

    assign n_b3_rule = rule_of(r_b2_el, r_b2_cl);
    assign n_b3_pk   = PK_W'(i_pwm_period) * PK_W'(step_k(n_b3_rule));
    assign w_pm      = PM_W'(i_pwm_period) * PM_W'(step_magic(n_b3_rule));
    assign n_b3_step = w_pm[STEP_SH +: STEP_W];

    // down steps only when the duty covers the exact step, up steps only while the duty is at most 0.8 of period
    always_comb begin
        n_duty = r_duty;
        if (r_b3_rule < LVL_Z) begin
            if (GUARD_W'(r_duty) * GUARD_W'(10000) >= GUARD_W'(r_b3_pk)) begin
                n_duty = r_duty - DUTY_W'(r_b3_step);
            end
        end else if (r_b3_rule > LVL_Z) begin
            if (UP_W'(r_duty) * UP_W'(10) <= UP_W'(i_pwm_period) * UP_W'(8)) begin
                n_duty = r_duty + DUTY_W'(r_b3_step);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid  <= 1'b0;
            r_b2_valid  <= 1'b0;
            r_b3_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_prev_err  <= '0;
            r_duty      <= '0;
        end else if (w_adv) begin
            r_b1_valid  <= o_pop;
            r_b2_valid  <= r_b1_valid;
            r_b3_valid  <= r_b2_valid;
            r_out_valid <= r_b3_valid;
            if (o_pop) begin
                r_prev_err <= n_b1_err;
            end
            if (r_b3_valid) begin
                r_duty <= n_duty;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_b1_mv   <= i_mv;
            r_b1_err  <= n_b1_err;
            r_b1_chg  <= n_b1_chg;
            r_b2_mv   <= r_b1_mv;
            r_b2_el   <= classify(r_b1_err, i_ref_mv);
            r_b2_cl   <= classify(r_b1_chg, i_ref_mv);
            r_b3_mv   <= r_b2_mv;
            r_b3_el   <= r_b2_el;
            r_b3_cl   <= r_b2_cl;
            r_b3_rule <= n_b3_rule;
            r_b3_pk   <= n_b3_pk;
            r_b3_step <= n_b3_step;
            r_out.duty         <= n_duty;
            r_out.measured_mv  <= r_b3_mv;
            r_out.error_level  <= r_b3_el;
            r_out.change_level <= r_b3_cl;
            r_out.rule_level   <= r_b3_rule;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    `FDR_ASSERT_NEXT(a_duty_hold, !(w_adv && r_b3_valid), $stable(r_duty), "duty moved without a beat")
    `FDR_ASSERT_NEXT(a_zero_rule, w_adv && r_b3_valid && r_b3_rule == LVL_Z, r_duty == $past(r_duty), "duty moved on zero rule")
    `FDR_ASSERT_NEXT(a_down_rule, w_adv && r_b3_valid && r_b3_rule < LVL_Z, r_duty <= $past(r_duty), "down rule raised duty")

endmodule

@@ rtl/fuzzy_duty_regulator.sv @@
// Fuzzy PD duty regulator. Each input beat carries five 12-bit ADC samples of
// one control tick; the block averages them, scales to millivolts, sorts the
// error and its change against ref_mv into eleven classes, applies the rule
// table and returns the updated duty with the intermediate classes as one
// output beat. A three-stage front end (sum, divide, scale) feeds a four-entry
// queue; a four-stage back end (error, classify, rule and step, duty update)
// drains it, so a new beat is taken every clock when neither side stalls.
// The duty and previous-error registers close their loops within single
// back-end stages, which is what allows one beat per clock. Configuration
// writes take effect at once and belong in idle periods; writes to an
// unknown index are dropped.
module fuzzy_duty_regulator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  fdr_pkg::t_in_item               i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output fdr_pkg::t_out_item              o_out_data,
    input  logic                            i_cfg_we,
    input  logic [fdr_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [fdr_pkg::CFG_DATA_W-1:0]  i_cfg_wdata
);
    import fdr_pkg::*;

    logic [REF_W-1:0] r_ref_mv;
    logic [PER_W-1:0] r_pwm_period;
    logic             w_push;
    logic             w_pop;
    logic [MV_W-1:0]  w_front_mv;
    logic [MV_W-1:0]  w_q_mv;
    t_q_status        w_q_status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_mv     <= REF_MV_RESET;
            r_pwm_period <= PWM_PERIOD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_REF_MV:     r_ref_mv     <= i_cfg_wdata[REF_W-1:0];
                CFG_PWM_PERIOD: r_pwm_period <= i_cfg_wdata[PER_W-1:0];
                default: ;
            endcase
        end
    end

    fdr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_in_data  (i_in_data),
        .o_push     (w_push),
        .i_full     (w_q_status.full),
        .o_mv       (w_front_mv)
    );

    fdr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_front_mv),
        .i_pop    (w_pop),
        .o_status (w_q_status),
        .o_data   (w_q_mv)
    );

    fdr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ref_mv     (r_ref_mv),
        .i_pwm_period (r_pwm_period),
        .i_q_status   (w_q_status),
        .i_mv         (w_q_mv),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_out_data   (o_out_data)
    );

endmodule

@@ test/fuzzy_duty_regulator_check.sv @@
`timescale 1ns / 100ps

module fuzzy_duty_regulator_check (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    input  logic                           i_in_stall,
    input  fdr_pkg::t_in_item              i_in_data,
    input  logic                           i_out_valid,
    input  logic                           i_out_stall,
    input  fdr_pkg::t_out_item             i_out_data,
    input  logic                           i_cfg_we,
    input  logic [fdr_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [fdr_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                             o_ticks_in_flight,
    output int                             o_mismatches
);
    import fdr_pkg::*;

    // shadow of the block's registers and state
    int     tgt_mv;
    int     period_cnt;
    int     err_last;
    longint duty_cur;

    t_out_item duty_updates [$];
    t_out_item want;
    int        bad_cnt = 0;

    function automatic logic [LVL_W-1:0] level_of(input int x, input int r);
        longint v;
        longint t;
        v = longint'(x) * 1000;
        t = longint'(r);
        if (v > -5 * t && v <= 5 * t) return LVL_Z;
        if (v > 5 * t && v <= 100 * t) return LVL_PT;
        if (v > -100 * t && v <= -5 * t) return LVL_NT;
        if (v > 100 * t && v <= 200 * t) return LVL_PS;
        if (v > -200 * t && v <= -100 * t) return LVL_NS;
        if (v > 200 * t && v <= 350 * t) return LVL_PM;
        if (v > -350 * t && v <= -200 * t) return LVL_NM;
        if (v > 350 * t && v <= 450 * t) return LVL_PH;
        if (v > -450 * t && v <= -350 * t) return LVL_NH;
        if (v > 450 * t) return LVL_PE;
        return LVL_NE;
    endfunction

    function automatic logic [LVL_W-1:0] rule_for(input logic [LVL_W-1:0] el,
                                                  input logic [LVL_W-1:0] cl);
        int s;
        int m;
        int mag;
        s = int'(el) + int'(cl) - 10;
        m = (s < 0) ? -s : s;
        if (m == 0) mag = 0;
        else if (m == 1) mag = 1;
        else if (m == 2) mag = 2;
        else if (m <= 4) mag = 3;
        else if (m <= 6) mag = 4;
        else mag = 5;
        return LVL_W'((s < 0) ? 5 - mag : 5 + mag);
    endfunction

    // duty step per rule class, in units of 1/10000 of the period
    function automatic longint step_per_10k(input logic [LVL_W-1:0] rl);
        case (rl)
            LVL_NE, LVL_PE: return 625;
            LVL_NH:         return 370;
            LVL_PH:         return 400;
            LVL_NM, LVL_PM: return 250;
            LVL_NS, LVL_PS: return 120;
            LVL_NT, LVL_PT: return 50;
            default:        return 0;
        endcase
    endfunction

    function automatic t_out_item regulate(input t_in_item t);
        int        smp [NUM_SAMPLE_FIELDS];
        int        sum;
        int        mv;
        int        err;
        int        chg;
        longint    d;
        longint    p;
        longint    k;
        t_out_item r;
        smp[0] = t.sample_0;
        smp[1] = t.sample_1;
        smp[2] = t.sample_2;
        smp[3] = t.sample_3;
        smp[4] = t.sample_4;
        sum = 0;
        for (int i = 0; i < N_AVG; i++) sum += smp[i];
        mv = (sum / N_AVG) * 3300 / 4095;
        err = tgt_mv - mv;
        chg = err - err_last;
        r.measured_mv  = mv[MV_W-1:0];
        r.error_level  = level_of(err, tgt_mv);
        r.change_level = level_of(chg, tgt_mv);
        r.rule_level   = rule_for(r.error_level, r.change_level);
        d = duty_cur;
        p = period_cnt;
        k = step_per_10k(r.rule_level);
        if (r.rule_level < LVL_Z) begin
            if (d * 10000 >= p * k) d = d - (p * k) / 10000;
        end else if (r.rule_level > LVL_Z) begin
            if (d * 10 <= p * 8) d = d + (p * k) / 10000;
        end
        duty_cur = d & 64'hFFFF;
        err_last = err;
        r.duty = duty_cur[DUTY_W-1:0];
        return r;
    endfunction

    function automatic void compare(input string name, input logic [15:0] exp_v,
                                    input logic [15:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            bad_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tgt_mv = REF_MV_RESET;
            period_cnt = PWM_PERIOD_RESET;
            err_last = 0;
            duty_cur = 0;
            duty_updates.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_REF_MV:     tgt_mv = i_cfg_wdata[REF_W-1:0];
                    CFG_PWM_PERIOD: period_cnt = i_cfg_wdata[PER_W-1:0];
                    default: ;
                endcase
            end
            if (i_in_valid && !i_in_stall) duty_updates.push_back(regulate(i_in_data));
            if (i_out_valid && !i_out_stall) begin
                if (duty_updates.size() == 0) begin
                    $error("result beat with no tick waiting: duty %0d mv %0d",
                           i_out_data.duty, i_out_data.measured_mv);
                    bad_cnt++;
                end else begin
                    want = duty_updates.pop_front();
                    compare("duty", 16'(want.duty), 16'(i_out_data.duty));
                    compare("measured_mv", 16'(want.measured_mv), 16'(i_out_data.measured_mv));
                    compare("error_level", 16'(want.error_level), 16'(i_out_data.error_level));
                    compare("change_level", 16'(want.change_level),
                            16'(i_out_data.change_level));
                    compare("rule_level", 16'(want.rule_level), 16'(i_out_data.rule_level));
                end
            end
        end
        o_ticks_in_flight <= duty_updates.size();
        o_mismatches <= bad_cnt;
    end

endmodule

@@ test/fuzzy_duty_regulator_test.sv @@
`timescale 1ns / 100ps

module fuzzy_duty_regulator_test;
    import fdr_pkg::*;

    localparam int IDLE_LIMIT  = 2000;
    localparam int HOLD_CYCLES = 120;
    localparam int PHASES      = 8;
    localparam int PHASE_TICKS = 116;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  in_valid = 1'b0;
    logic                  in_stall;
    t_in_item              in_data = '0;
    logic                  out_valid;
    logic                  out_stall = 1'b0;
    t_out_item             out_data;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = CFG_REF_MV;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    ticks_in_flight;
    int                    mismatches;

    int hold_asks = 0;
    int hold_done = 0;
    int hold_left = 0;
    int stall_mode = 0;
    int mode_left = 0;
    int rx_cycle = 0;
    int idle_cnt = 0;
    int center = 0;

    always #10 clk = ~clk;

    fuzzy_duty_regulator DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    fuzzy_duty_regulator_check checker_i (
        .i_clk             (clk),
        .i_rst_n           (rst_n),
        .i_in_valid        (in_valid),
        .i_in_stall        (in_stall),
        .i_in_data         (in_data),
        .i_out_valid       (out_valid),
        .i_out_stall       (out_stall),
        .i_out_data        (out_data),
        .i_cfg_we          (cfg_we),
        .i_cfg_idx         (cfg_idx),
        .i_cfg_wdata       (cfg_wdata),
        .o_ticks_in_flight (ticks_in_flight),
        .o_mismatches      (mismatches)
    );

    // receiver: stall pattern changes now and then, plus requested long hold-offs
    always @(posedge clk) begin
        rx_cycle++;
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (hold_asks != hold_done) begin
            hold_done++;
            hold_left = HOLD_CYCLES;
            out_stall <= 1'b1;
        end else begin
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (stall_mode)
                0:       out_stall <= 1'b0;
                1:       out_stall <= ($urandom_range(0, 3) == 0);
                2:       out_stall <= ($urandom_range(0, 3) != 0);
                default: out_stall <= ((rx_cycle % 5) < 2);
            endcase
        end
    end

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cnt = 0;
            else idle_cnt++;
            if (idle_cnt >= IDLE_LIMIT) begin
                $display("[fuzzy_duty_regulator] ERROR");
                $finish;
            end
        end
    end

    function automatic logic [SMP_W-1:0] clip12(input int v);
        if (v < 0) return '0;
        if (v > 4095) return 12'hFFF;
        return SMP_W'(v);
    endfunction

    function automatic t_in_item tick_of(input int a, input int b, input int c, input int d,
                                         input int e);
        t_in_item t;
        t.sample_0 = clip12(a);
        t.sample_1 = clip12(b);
        t.sample_2 = clip12(c);
        t.sample_3 = clip12(d);
        t.sample_4 = clip12(e);
        return t;
    endfunction

    function automatic t_in_item flat(input int v);
        return tick_of(v, v, v, v, v);
    endfunction

    // mostly samples around the setpoint, with some wild and saturated ticks
    function automatic t_in_item pick_tick(input int c);
        int mode;
        int off;
        int sp;
        int v [5];
        mode = $urandom_range(0, 9);
        case ($urandom_range(0, 3))
            0:       off = $urandom_range(0, 8) - 4;
            1:       off = $urandom_range(0, 80) - 40;
            2:       off = $urandom_range(0, 600) - 300;
            default: off = $urandom_range(0, 3000) - 1500;
        endcase
        sp = $urandom_range(0, 6);
        for (int i = 0; i < 5; i++) begin
            if (mode == 0) v[i] = $urandom_range(0, 4095);
            else if (mode == 1) v[i] = $urandom_range(0, 1) ? 4095 : 0;
            else v[i] = c + off + $urandom_range(0, 2 * sp) - sp;
        end
        return tick_of(v[0], v[1], v[2], v[3], v[4]);
    endfunction

    task automatic put_tick(input t_in_item t);
        in_valid <= 1'b1;
        in_data <= t;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic idle_for(input int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // hold input until every tick in flight has come back
    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge clk); while (ticks_in_flight != 0);
    endtask

    task automatic set_regs(input int tgt, input int per);
        cfg_we <= 1'b1;
        cfg_idx <= CFG_REF_MV;
        cfg_wdata <= CFG_DATA_W'(tgt);
        @(posedge clk);
        cfg_idx <= CFG_PWM_PERIOD;
        cfg_wdata <= CFG_DATA_W'(per);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        center = tgt * 4095 / 3300;
        if (center > 4095) center = 4095;
    endtask

    task automatic directed();
        // zero setpoint after reset: any nonzero error or change lands on an outer class
        put_tick(flat(0));
        put_tick(flat(4095));
        put_tick(flat(12'h555));
        put_tick(flat(12'hAAA));
        put_tick(tick_of(4095, 0, 4095, 0, 4095));
        drain();
        // widest period, drive the duty high
        set_regs(4095, 65535);
        repeat (10) put_tick(flat(0));
        put_tick(flat(4095));
        put_tick(tick_of(0, 4095, 0, 4095, 0));
        drain();
        // period dropped far below the duty
        set_regs(1650, 100);
        repeat (3) put_tick(flat(4095));
        put_tick(flat(center));
        drain();
        set_regs(1, 1);
        put_tick(flat(0));
        put_tick(flat(4095));
        drain();
        // zero period freezes the duty
        set_regs(2000, 0);
        put_tick(flat(0));
        put_tick(flat(4095));
        put_tick(flat(center));
        drain();
    endtask

    initial begin
        int tgt;
        int per;
        int burst;
        int gap;
        bit no_gaps;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        directed();
        for (int ph = 0; ph < PHASES; ph++) begin
            case ($urandom_range(0, 5))
                0:       tgt = 0;
                1:       tgt = 4095;
                2:       tgt = 1;
                default: tgt = $urandom_range(100, 3300);
            endcase
            case ($urandom_range(0, 4))
                0:       per = 1;
                1:       per = 65535;
                2:       per = 1000;
                3:       per = $urandom_range(1, 50);
                default: per = $urandom_range(1, 65535);
            endcase
            if (ph == 0) begin
                tgt = 1650;
                per = 65535;
            end
            drain();
            set_regs(tgt, per);
            no_gaps = ($urandom_range(0, 3) == 0);
            burst = 0;
            for (int n = 0; n < PHASE_TICKS; n++) begin
                if (ph == 2 && n == 40) hold_asks++;
                if (ph == 5 && n == 60) drain();
                if (burst == 0) begin
                    burst = $urandom_range(1, 40);
                    gap = no_gaps ? 0 : $urandom_range(0, 10);
                    if (gap > 0) idle_for(gap);
                end
                burst--;
                put_tick(pick_tick(center));
            end
        end
        drain();
        repeat (24) @(posedge clk);
        if (mismatches == 0 && ticks_in_flight == 0) begin
            $display("[fuzzy_duty_regulator] OK");
        end else begin
            $display("[fuzzy_duty_regulator] ERROR");
        end
        $finish;
    end

endmodule
